>>> design/sinc_interpolation_reconstructor_top_assert.svh
// Assertion macros used by the checker of the sinc reconstructor.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef SINC_INTERPOLATION_RECONSTRUCTOR_TOP_ASSERT_SVH
`define SINC_INTERPOLATION_RECONSTRUCTOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define SIR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sir_pkg.sv
`default_nettype none
package sir_pkg;

  localparam int DEPTH       = 256;
  localparam int FRAC_BITS   = 8;
  localparam int SAMPLE_BITS = 16;

  localparam int QT_W   = 16;
  localparam int OUT_W  = 24;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;

  // Offset d = query - (index << FRAC_BITS), signed
  localparam int POS_W = (QT_W > ADDR_W + FRAC_BITS) ? QT_W : ADDR_W + FRAC_BITS;
  localparam int D_W   = POS_W + 1;
  localparam int MAG_W = POS_W;

  // Sine phase and table lookup
  localparam int PHASE_W = 16;
  localparam int SINE_W  = 16;
  localparam int IDX_W   = 5;
  localparam int FR_W    = 11;

  // Weight division
  localparam int PI_W      = 15;
  localparam int PI_Q13    = 25736;
  localparam int NUM_SHIFT = FRAC_BITS + 13;
  localparam int DEN_W     = PI_W + MAG_W;
  localparam int NUM_W     = SINE_W + NUM_SHIFT + 1;
  localparam int QUO_W     = 17;
  localparam int W_W       = QUO_W + 1;

  // Accumulation and output rounding
  localparam int PROD_W      = SAMPLE_BITS + W_W;
  localparam int ACC_W       = PROD_W + ADDR_W;
  localparam int ROUND_SHIFT = 15;
  localparam int ROUND_HALF  = 1 << (ROUND_SHIFT - 1);
  localparam int OUT_MAX     = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN     = -(1 << (OUT_W - 1));

  localparam logic [SINE_W-1:0] SINC_ONE = SINE_W'(32768);

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // Quarter-wave sine in Q15, 16 segments plus the end point
  function automatic logic [SINE_W-1:0] sine_q15(input logic [IDX_W-1:0] idx);
    logic [SINE_W-1:0] v;
    case (idx)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd3212;
      5'd2:    v = 16'd6393;
      5'd3:    v = 16'd9512;
      5'd4:    v = 16'd12540;
      5'd5:    v = 16'd15447;
      5'd6:    v = 16'd18205;
      5'd7:    v = 16'd20788;
      5'd8:    v = 16'd23170;
      5'd9:    v = 16'd25330;
      5'd10:   v = 16'd27246;
      5'd11:   v = 16'd28899;
      5'd12:   v = 16'd30274;
      5'd13:   v = 16'd31357;
      5'd14:   v = 16'd32138;
      5'd15:   v = 16'd32610;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> design/sir_divider.sv
`default_nettype none
module sir_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sir_pkg::NUM_W-1:0]  num,
  input  logic [sir_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [sir_pkg::QUO_W-1:0]  quo
);
  import sir_pkg::*;

  localparam int DSH_W = DEN_W + QUO_W - 1;
  localparam int STEP_W = $clog2(QUO_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [NUM_W-1:0]  rem_r;
  logic [DSH_W-1:0]  dsh_r;
  logic [QUO_W-1:0]  quo_r;

  logic [DSH_W-1:0]  rem_ext;
  logic [DSH_W-1:0]  rem_diff;
  logic              ge;

  assign rem_ext  = DSH_W'(rem_r);
  assign ge       = rem_ext >= dsh_r;
  assign rem_diff = rem_ext - dsh_r;
  assign done     = done_r;
  assign quo      = quo_r;

  // restoring division, one quotient bit per cycle, MSB first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      dsh_r  <= {den, {(QUO_W-1){1'b0}}};
      quo_r  <= '0;
      step_r <= STEP_W'(QUO_W - 1);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_diff[NUM_W-1:0];
      end
      quo_r  <= {quo_r[QUO_W-2:0], ge};
      dsh_r  <= dsh_r >> 1;
      step_r <= step_r - STEP_W'(1);
    end
  end

endmodule
`default_nettype wire

>>> design/sinc_interpolation_reconstructor_top.sv
`default_nettype none
// Sinc (Whittaker-Shannon) interpolation reconstructor.
// Input channel (in_valid/in_ready) carries one beat per command: opcode 0
// clears the sample buffer, opcode 1 appends in_sample_value (dropped when
// 256 samples are already held), opcode 2 asks for the value at in_query_time
// (sample periods, 8 fraction bits). Opcode 3 is ignored.
// Output channel (out_valid/out_ready) carries one beat per query: the
// saturated 24-bit sum, a saturation flag and an empty-buffer flag.
// Clear and append are handled in the idle state; in_ready stays high after them.
// A query walks every stored sample through one sequence: memory read,
// sine lookup, denominator multiply, a 17-step shared serial divider and a
// multiply-accumulate; the divider is skipped when the offset is zero. An
// empty buffer goes straight to the result.
// in_ready is low for the whole query. The result sits in an output
// register; further clears and appends are taken while it waits, and a
// following query holds its result until the receiver takes the pending one.
// Reset (rst_n low, synchronous) empties the buffer and drops any pending
// result; stored sample data is not cleared.
module sinc_interpolation_reconstructor_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             in_opcode,
  input  logic signed [sir_pkg::SAMPLE_BITS-1:0] in_sample_value,
  input  logic [sir_pkg::QT_W-1:0]               in_query_time,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [sir_pkg::OUT_W-1:0]       out_value,
  output logic                                   out_saturated,
  output logic                                   out_buffer_empty
);
  import sir_pkg::*;

  localparam logic [PI_W-1:0]        PI_V   = PI_W'(PI_Q13);
  localparam logic signed [ACC_W:0]  LIM_HI = (ACC_W+1)'(OUT_MAX);
  localparam logic signed [ACC_W:0]  LIM_LO = (ACC_W+1)'(OUT_MIN);
  localparam logic [PHASE_W-1:0]     HALF_TURN = PHASE_W'(1 << (PHASE_W - 1));

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDR,
    ST_SINE,
    ST_DEN,
    ST_DIVGO,
    ST_DIV,
    ST_MAC,
    ST_ACC,
    ST_FIN
  } state_t;

  state_t                       state_r;
  logic [CNT_W-1:0]             count_r;
  logic [ADDR_W-1:0]            idx_r;
  logic [QT_W-1:0]              qt_r;
  logic                         empty_r;

  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_r;

  logic signed [D_W-1:0]        d_r;
  logic [SINE_W-1:0]            base_r;
  logic [SINE_W+FR_W-1:0]       interp_r;
  logic [MAG_W-1:0]             mag_r;
  logic                         neg_r;
  logic                         zero_r;
  logic [SINE_W-1:0]            s_r;
  logic [DEN_W-1:0]             den_r;
  logic signed [W_W-1:0]        w_r;
  logic signed [PROD_W-1:0]     mac_r;
  logic signed [ACC_W-1:0]      acc_r;

  logic                         out_valid_r;
  logic signed [OUT_W-1:0]      out_value_r;
  logic                         out_saturated_r;
  logic                         out_buffer_empty_r;

  logic                         accept;
  logic                         store_ok;
  logic                         last_sample;
  logic                         out_free;
  logic [PHASE_W-1:0]           phase;
  logic [PHASE_W-1:0]           fold;
  logic [IDX_W-1:0]             tidx;
  logic [FR_W-1:0]              tfr;
  logic [SINE_W-1:0]            slope;
  logic                         dneg;
  logic                         odd;
  logic [D_W-1:0]               d_abs;
  logic [SINE_W-1:0]            s_sum;
  logic                         div_start;
  logic                         div_done;
  logic [NUM_W-1:0]             div_num;
  logic [QUO_W-1:0]             div_quo;
  logic signed [W_W-1:0]        quo_s;
  logic signed [ACC_W:0]        rnd_sum;
  logic signed [ACC_W:0]        rnd_q;
  logic                         sat_hi;
  logic                         sat_lo;

  assign in_ready    = (state_r == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign store_ok    = count_r < CNT_W'(DEPTH);
  assign last_sample = ({1'b0, idx_r} + CNT_W'(1)) == count_r;
  assign out_free    = !out_valid_r || out_ready;

  // fold the fractional offset onto a quarter wave of sin(pi * f)
  assign phase = {d_r[FRAC_BITS-1:0], {(PHASE_W-FRAC_BITS){1'b0}}};
  assign fold  = (phase > HALF_TURN) ? (PHASE_W'(0) - phase) : phase;
  assign tidx  = fold[FR_W +: IDX_W];
  assign tfr   = fold[FR_W-1:0];
  assign slope = sine_q15(tidx + IDX_W'(1)) - sine_q15(tidx);
  assign dneg  = d_r[D_W-1];
  assign odd   = d_r[FRAC_BITS];
  assign d_abs = dneg ? (D_W'(0) - d_r) : d_r;

  assign s_sum   = base_r + interp_r[SINE_W+FR_W-1:FR_W];
  assign div_num = NUM_W'({s_r, {NUM_SHIFT{1'b0}}}) + NUM_W'(den_r >> 1);
  assign div_start = (state_r == ST_DIVGO);
  assign quo_s   = $signed({1'b0, div_quo});

  // round the Q15 sum to an integer (floor of sum + half), then clip to the output range
  assign rnd_sum = (ACC_W+1)'(acc_r) + (ACC_W+1)'(ROUND_HALF);
  assign rnd_q   = rnd_sum >>> ROUND_SHIFT;
  assign sat_hi  = rnd_q > LIM_HI;
  assign sat_lo  = rnd_q < LIM_LO;

  sir_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sample memory: write on append, registered read per walked sample
  always_ff @(posedge clk) begin
    if (accept && in_opcode == OP_APPEND && store_ok) begin
      mem[count_r[ADDR_W-1:0]] <= in_sample_value;
    end
    if (state_r == ST_ADDR) begin
      rd_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the taken beat; a finishing query reloads the register instead
      if (out_valid_r && out_ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_opcode)
              OP_CLEAR: begin
                count_r <= '0;
              end
              OP_APPEND: begin
                // drop the beat when the buffer is full
                if (store_ok) begin
                  count_r <= count_r + CNT_W'(1);
                end
              end
              OP_QUERY: begin
                qt_r    <= in_query_time;
                idx_r   <= '0;
                acc_r   <= '0;
                empty_r <= (count_r == '0);
                state_r <= (count_r == '0) ? ST_FIN : ST_ADDR;
              end
              default: begin
              end
            endcase
          end
        end
        ST_ADDR: begin
          d_r     <= $signed(D_W'(qt_r) - D_W'({idx_r, {FRAC_BITS{1'b0}}}));
          state_r <= ST_SINE;
        end
        ST_SINE: begin
          base_r   <= sine_q15(tidx);
          interp_r <= {{FR_W{1'b0}}, slope} * {{SINE_W{1'b0}}, tfr};
          mag_r    <= d_abs[MAG_W-1:0];
          neg_r    <= odd ^ dneg;
          zero_r   <= (d_r == '0);
          state_r  <= ST_DEN;
        end
        ST_DEN: begin
          s_r   <= s_sum;
          den_r <= {{MAG_W{1'b0}}, PI_V} * {{PI_W{1'b0}}, mag_r};
          if (zero_r) begin
            w_r     <= $signed({{(W_W-SINE_W){1'b0}}, SINC_ONE});
            state_r <= ST_MAC;
          end else begin
            state_r <= ST_DIVGO;
          end
        end
        ST_DIVGO: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            w_r     <= neg_r ? -quo_s : quo_s;
            state_r <= ST_MAC;
          end
        end
        ST_MAC: begin
          mac_r   <= PROD_W'(rd_r) * PROD_W'(w_r);
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          acc_r <= acc_r + ACC_W'(mac_r);
          if (last_sample) begin
            state_r <= ST_FIN;
          end else begin
            idx_r   <= idx_r + ADDR_W'(1);
            state_r <= ST_ADDR;
          end
        end
        ST_FIN: begin
          // hold the result until the output register is free
          if (out_free) begin
            out_valid_r        <= 1'b1;
            out_saturated_r    <= sat_hi || sat_lo;
            out_buffer_empty_r <= empty_r;
            if (sat_hi) begin
              out_value_r <= OUT_W'(OUT_MAX);
            end else if (sat_lo) begin
              out_value_r <= OUT_W'(OUT_MIN);
            end else begin
              out_value_r <= rnd_q[OUT_W-1:0];
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_saturated    = out_saturated_r;
  assign out_buffer_empty = out_buffer_empty_r;

endmodule
`default_nettype wire

>>> design/sir_checker.sv
`default_nettype none
`include "sinc_interpolation_reconstructor_top_assert.svh"
module sir_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic [1:0]                             in_opcode,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [sir_pkg::OUT_W-1:0]       out_value,
  input logic                                   out_saturated,
  input logic                                   out_buffer_empty
);
  import sir_pkg::*;

  `SIR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value), "result dropped or changed while stalled")
  `SIR_ASSERT_NOW(a_empty_zero, out_valid && out_buffer_empty, out_value == '0 && !out_saturated, "empty buffer result not zero")
  `SIR_ASSERT_NOW(a_sat_rail, out_valid && out_saturated, out_value == OUT_W'(OUT_MAX) || out_value == OUT_W'(OUT_MIN), "saturated result off the rails")
  `SIR_ASSERT_NEXT(a_fill_fast, in_valid && in_ready && in_opcode != OP_QUERY, in_ready, "clear or append did not finish in one cycle")
  `SIR_ASSERT_NEXT(a_query_busy, in_valid && in_ready && in_opcode == OP_QUERY, !in_ready, "query did not start the sequencer")

endmodule

bind sinc_interpolation_reconstructor_top sir_checker u_sir_checker (.*);
`default_nettype wire

>>> verif/tb.sv
`default_nettype none
module tb;
  import sir_pkg::*;

  // Opcode 3 carries no meaning; the block drops it without a result.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Quarter-wave sine, Q15, 16 segments plus the end point.
  localparam int QUARTER_SINE [0:16] = '{
    0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
    25330, 27246, 28899, 30274, 31357, 32138, 32610, 32768
  };

  // Hard limit on the length of the run; the longest run here stays well
  // below a tenth of it.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    saturated;
    logic                    buffer_empty;
  } recon_t;

  // Shadow of the sample buffer plus the queue of reconstructions that
  // are still owed by the block.
  class sinc_scoreboard;
    logic signed [SAMPLE_BITS-1:0] samples [DEPTH];
    int unsigned stored = 0;
    recon_t      owed_q[$];
    int          errors = 0;

    // Interpolated sin(pi * frac / 2^FRAC_BITS), Q15.
    function longint sine_interp(int unsigned frac);
      int unsigned u;
      int unsigned seg;
      int unsigned part;
      u = (frac << (16 - FRAC_BITS)) & 32'hFFFF;
      if (u > 32768) u = 65536 - u;
      seg  = u >> 11;
      part = u & 2047;
      if (seg >= 16) return QUARTER_SINE[16];
      return longint'(QUARTER_SINE[seg]) +
             ((longint'(QUARTER_SINE[seg + 1] - QUARTER_SINE[seg]) * part) >>> 11);
    endfunction

    // Sinc weight in Q15 for an offset with FRAC_BITS fraction bits.
    function longint sinc_weight_q15(longint d);
      int unsigned frac;
      bit          odd;
      bit          dneg;
      longint      s;
      longint      mag;
      longint      num;
      longint      den;
      longint      w;
      if (d == 0) return 32768;
      frac = 32'(d[FRAC_BITS-1:0]);
      odd  = d[FRAC_BITS];
      dneg = (d < 0);
      s    = sine_interp(frac);
      // Integer offsets land on a zero of the sine.
      if (s == 0) return 0;
      mag = dneg ? -d : d;
      num = s << (FRAC_BITS + 13);
      den = longint'(PI_Q13) * mag;
      w   = (num + den / 2) / den;
      return (odd != dneg) ? -w : w;
    endfunction

    function recon_t reconstruct(logic [QT_W-1:0] qt);
      recon_t r;
      longint acc;
      longint d;
      longint v;
      r = '0;
      if (stored == 0) begin
        r.buffer_empty = 1'b1;
        return r;
      end
      acc = 0;
      for (int i = 0; i < stored; i++) begin
        d   = longint'(qt) - (longint'(i) << FRAC_BITS);
        acc += longint'(samples[i]) * sinc_weight_q15(d);
      end
      v = (acc + ROUND_HALF) >>> ROUND_SHIFT;
      if (v > OUT_MAX) begin
        v = OUT_MAX;
        r.saturated = 1'b1;
      end else if (v < OUT_MIN) begin
        v = OUT_MIN;
        r.saturated = 1'b1;
      end
      r.value = v[OUT_W-1:0];
      return r;
    endfunction

    function void note_input(logic [1:0] op, logic signed [SAMPLE_BITS-1:0] sv,
                             logic [QT_W-1:0] qt);
      case (op)
        OP_CLEAR: stored = 0;
        OP_APPEND: begin
          if (stored < DEPTH) begin
            samples[stored] = sv;
            stored++;
          end
        end
        OP_QUERY: owed_q = {owed_q, reconstruct(qt)};
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [OUT_W-1:0] value, logic saturated,
                               logic buffer_empty);
      recon_t exp_r;
      if (owed_q.size() == 0) begin
        $error("out beat with no query waiting: value %0d", value);
        errors++;
        return;
      end
      exp_r = owed_q.pop_front();
      if (value !== exp_r.value) begin
        $error("value: expected %0d, got %0d", exp_r.value, value);
        errors++;
      end
      if (saturated !== exp_r.saturated) begin
        $error("saturated: expected %0d, got %0d", exp_r.saturated, saturated);
        errors++;
      end
      if (buffer_empty !== exp_r.buffer_empty) begin
        $error("buffer_empty: expected %0d, got %0d", exp_r.buffer_empty, buffer_empty);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic                          clk              = 1'b0;
  logic                          rst_n            = 1'b0;
  logic                          in_valid         = 1'b0;
  logic                          in_ready;
  logic [1:0]                    in_opcode        = OP_CLEAR;
  logic signed [SAMPLE_BITS-1:0] in_sample_value  = '0;
  logic [QT_W-1:0]               in_query_time    = '0;
  logic                          out_valid;
  logic                          out_ready        = 1'b0;
  logic signed [OUT_W-1:0]       out_value;
  logic                          out_saturated;
  logic                          out_buffer_empty;

  sinc_scoreboard sb;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  int             items_sent    = 0;
  int             cycle_count   = 0;

  sinc_interpolation_reconstructor_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_sample_value  (in_sample_value),
    .in_query_time    (in_query_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_value        (out_value),
    .out_saturated    (out_saturated),
    .out_buffer_empty (out_buffer_empty)
  );

  always #6 clk = ~clk;

  // Hard stop: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: check each out beat against the oldest owed reconstruction,
  // then stall at random for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_value, out_saturated, out_buffer_empty);
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Drive one input beat; idle at random first, then hold the beat until
  // the block takes it. Returns at the accepting edge.
  task automatic send_beat(input logic [1:0] op, input logic signed [SAMPLE_BITS-1:0] sv,
                           input logic [QT_W-1:0] qt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_sample_value <= sv;
    in_query_time   <= qt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Opcode 3 and appends to a full buffer are dropped; don't count them.
    if (op != OP_UNUSED && !(op == OP_APPEND && sb.stored >= DEPTH))
      items_sent++;
    sb.note_input(op, sv, qt);
  endtask

  // Mostly random sample, with the extremes mixed in.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(11))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return 16'sh0001;
      4:       return 16'shFFFF;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Query time: mostly inside the stored span, sometimes on an integer
  // position, sometimes anywhere in the 16-bit range.
  function automatic logic [QT_W-1:0] pick_query(int unsigned count);
    int unsigned span;
    logic [QT_W-1:0] qt;
    span = count * 256 + 255;
    if (span > 65535) span = 65535;
    case ($urandom_range(9))
      0, 1: qt = QT_W'($urandom);
      2: begin
        qt = QT_W'($urandom_range(span));
        qt[FRAC_BITS-1:0] = '0;
      end
      3:       qt = QT_W'($urandom_range(span)) | 16'h0080;
      default: qt = QT_W'($urandom_range(span));
    endcase
    return qt;
  endfunction

  // Random part: mostly clear/append/query sequences with random content,
  // the rest stray beats. Keep the buffer short so queries stay cheap.
  task automatic run_random(input int target);
    int start;
    int n;
    int nq;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(3))
          0, 1:    send_beat(OP_UNUSED, SAMPLE_BITS'($urandom), QT_W'($urandom));
          2:       send_beat(OP_QUERY, SAMPLE_BITS'($urandom), QT_W'($urandom));
          default: send_beat(OP_APPEND, SAMPLE_BITS'($urandom), QT_W'($urandom));
        endcase
      end else begin
        if (sb.stored > 48 || $urandom_range(99) < 60)
          send_beat(OP_CLEAR, SAMPLE_BITS'($urandom), QT_W'($urandom));
        n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
        repeat (n) send_beat(OP_APPEND, pick_sample(), QT_W'($urandom));
        nq = $urandom_range(1, 3);
        repeat (nq) send_beat(OP_QUERY, SAMPLE_BITS'($urandom), pick_query(sb.stored));
      end
    end
  endtask

  initial begin
    sb = new;
    send_idle_pct = 19;
    recv_idle_pct = 63;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: query on an empty buffer, the dropped opcode, extremes.
    send_beat(OP_QUERY, 16'sh7FFF, 16'h0080);
    send_beat(OP_UNUSED, 16'sh8000, 16'hFFFF);
    send_beat(OP_CLEAR, 16'sh0000, 16'h0000);
    send_beat(OP_APPEND, 16'sh7FFF, 16'h0000);
    send_beat(OP_APPEND, 16'sh8000, 16'hFFFF);
    send_beat(OP_APPEND, 16'sh0000, 16'h0000);
    send_beat(OP_APPEND, 16'sh0001, 16'h0000);
    send_beat(OP_APPEND, 16'shFFFF, 16'h0000);
    send_beat(OP_APPEND, 16'sh4000, 16'h0000);
    // Zero offset, then integer offsets where every other weight is zero.
    send_beat(OP_QUERY, 16'sh0000, 16'h0000);
    send_beat(OP_QUERY, 16'sh0000, 16'h0100);
    send_beat(OP_QUERY, 16'sh0000, 16'h0500);
    // Half-period, tiny and near-integer fractions, and the far end.
    send_beat(OP_QUERY, 16'sh0000, 16'h0080);
    send_beat(OP_QUERY, 16'sh0000, 16'h0001);
    send_beat(OP_QUERY, 16'sh0000, 16'h02FF);
    send_beat(OP_QUERY, 16'sh0000, 16'h8000);
    send_beat(OP_QUERY, 16'sh7FFF, 16'hFFFF);
    send_beat(OP_UNUSED, 16'sh0000, 16'h0000);
    send_beat(OP_CLEAR, 16'shFFFF, 16'hFFFF);
    send_beat(OP_QUERY, 16'sh0000, 16'h0180);

    // Fill the buffer to capacity, push a few appends that must be dropped,
    // and query the full buffer at both ends and in between.
    send_beat(OP_CLEAR, SAMPLE_BITS'($urandom), QT_W'($urandom));
    repeat (DEPTH) send_beat(OP_APPEND, pick_sample(), QT_W'($urandom));
    repeat (3) send_beat(OP_APPEND, pick_sample(), QT_W'($urandom));
    send_beat(OP_QUERY, SAMPLE_BITS'($urandom), 16'h0040);
    send_beat(OP_QUERY, SAMPLE_BITS'($urandom), 16'h7F80);
    send_beat(OP_QUERY, SAMPLE_BITS'($urandom), 16'hFFFF);
    send_beat(OP_QUERY, SAMPLE_BITS'($urandom), QT_W'($urandom));
    send_beat(OP_CLEAR, SAMPLE_BITS'($urandom), QT_W'($urandom));

    // Random part in three idling phases.
    run_random(40);
    send_idle_pct = 63;
    recv_idle_pct = 19;
    run_random(40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(40);
    in_valid <= 1'b0;

    // Drain owed results, then watch a while for stray out beats.
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
